// ===== src/stepper_slew_limited_positioner_core_assert.svh =====
// Assertion macros for the positioner core.
// All checks run on i_clk and are held off while i_rst_n is low.
`ifndef STEPPER_SLEW_LIMITED_POSITIONER_CORE_ASSERT_SVH
`define STEPPER_SLEW_LIMITED_POSITIONER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SSLP_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sslp: same-cycle check failed");

// Next-cycle implication.
`define SSLP_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sslp: next-cycle check failed");

`endif

// ===== src/sslp_pkg.sv =====
package sslp_pkg;

    localparam int unsigned POSITION_BITS_DEF = 32;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_SET_TARGET = 3'd1,
        OP_CLEAR      = 3'd2,
        OP_ENERGIZE   = 3'd3,
        OP_DEENERGIZE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        CFG_STEPS_PER_MS = 2'd0,
        CFG_LOW_LIMIT    = 2'd1,
        CFG_HIGH_LIMIT   = 2'd2
    } t_cfg_idx;

    localparam logic [15:0]        STEPS_PER_MS_RST = 16'd1;
    localparam logic signed [31:0] LOW_LIMIT_RST    = -32'sd100000;
    localparam logic signed [31:0] HIGH_LIMIT_RST   = 32'sd100000;

    typedef struct packed {
        logic [2:0]         op;
        logic [31:0]        now_ms;
        logic signed [31:0] new_target;
    } t_cmd;

    typedef struct packed {
        logic               tick_done;
        logic signed [31:0] position_now;
        logic               at_target;
        logic               stall_flag;
    } t_res;

    typedef struct packed {
        logic [15:0]        steps_per_ms;
        logic signed [31:0] low_limit;
        logic signed [31:0] high_limit;
    } t_cfg;

    typedef struct packed {
        logic stalled;
        logic energized;
    } t_flags;

endpackage

// ===== src/sslp_if.sv =====
interface sslp_cmd_if;
    import sslp_pkg::*;
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sslp_res_if;
    import sslp_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sslp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/sslp_step.sv =====
module sslp_step #(
    parameter int unsigned POSITION_BITS = sslp_pkg::POSITION_BITS_DEF
) (
    input  sslp_pkg::t_cmd                i_cmd,
    input  sslp_pkg::t_cfg                i_cfg,
    input  sslp_pkg::t_flags              i_flags,
    input  logic signed [POSITION_BITS-1:0] i_position,
    input  logic signed [POSITION_BITS-1:0] i_target,
    input  logic [31:0]                   i_last_tick,
    output sslp_pkg::t_flags              o_flags,
    output logic signed [POSITION_BITS-1:0] o_position,
    output logic signed [POSITION_BITS-1:0] o_target,
    output logic [31:0]                   o_last_tick,
    output sslp_pkg::t_res                o_res
);
    import sslp_pkg::*;

    localparam int unsigned DW = POSITION_BITS + 1;
    localparam logic signed [33:0] PosMin = -(34'sd1 <<< (POSITION_BITS - 1));
    localparam logic signed [33:0] PosMax = (34'sd1 <<< (POSITION_BITS - 1)) - 34'sd1;

    logic signed [33:0]              min34, max34, lo34, hi34;
    logic signed [POSITION_BITS-1:0] lo, hi;
    logic signed [31:0]              lo32, hi32;
    logic [31:0]                     elapsed;
    logic [47:0]                     prod;
    logic [30:0]                     lim;
    logic signed [DW-1:0]            delta;
    logic signed [33:0]              delta34, lim34, nlim34, step34;
    logic signed [POSITION_BITS-1:0] np;
    logic                            below, above, can_move, moving, reject;

    // travel limits folded into the position range
    assign min34 = 34'(i_cfg.low_limit);
    assign max34 = 34'(i_cfg.high_limit);
    assign lo34  = (min34 < PosMin) ? PosMin : ((min34 > PosMax) ? PosMax : min34);
    assign hi34  = (max34 < PosMin) ? PosMin : ((max34 > PosMax) ? PosMax : max34);
    assign lo    = lo34[POSITION_BITS-1:0];
    assign hi    = hi34[POSITION_BITS-1:0];
    assign lo32  = 32'(lo);
    assign hi32  = 32'(hi);

    // slew step
    assign elapsed = i_cmd.now_ms - i_last_tick;
    assign prod    = elapsed * i_cfg.steps_per_ms;
    assign lim     = (prod[47:31] != 17'd0) ? '1 : prod[30:0];
    assign delta   = DW'(i_target) - DW'(i_position);
    assign delta34 = 34'(delta);
    assign lim34   = signed'({3'b000, lim});
    assign nlim34  = -lim34;
    assign step34  = (delta34 > lim34) ? lim34 : ((delta34 < nlim34) ? nlim34 : delta34);
    // step lies between zero and delta, so the sum stays representable
    assign np      = i_position + step34[POSITION_BITS-1:0];
    assign below   = np < lo;
    assign above   = np > hi;

    assign can_move = i_flags.energized && !i_flags.stalled;
    assign moving   = can_move && (i_position != i_target);
    // lo and hi sit inside the position range, so this also rejects
    // targets that do not fit
    assign reject   = (i_cmd.new_target < lo32) || (i_cmd.new_target > hi32);

    always_comb begin
        o_flags     = i_flags;
        o_position  = i_position;
        o_target    = i_target;
        o_last_tick = i_last_tick;
        o_res.tick_done = 1'b0;
        unique case (i_cmd.op)
            OP_TICK: begin
                if (moving) begin
                    o_last_tick = i_cmd.now_ms;
                    if (below || above) begin
                        o_position      = below ? lo : hi;
                        o_flags.stalled = 1'b1;
                    end else begin
                        o_position      = np;
                        o_res.tick_done = (np == i_target);
                    end
                end else begin
                    o_res.tick_done = can_move;
                end
            end
            OP_SET_TARGET: begin
                if (reject) begin
                    o_flags.stalled = 1'b1;
                end else begin
                    o_target        = i_cmd.new_target[POSITION_BITS-1:0];
                    o_flags.stalled = 1'b0;
                end
            end
            OP_CLEAR: begin
                o_flags.stalled = 1'b0;
            end
            OP_ENERGIZE: begin
                o_flags.energized = 1'b1;
            end
            OP_DEENERGIZE: begin
                o_flags.energized = 1'b0;
            end
            default: begin
            end
        endcase
        o_res.position_now = 32'(o_position);
        o_res.at_target    = (o_position == o_target);
        o_res.stall_flag   = o_flags.stalled;
    end

endmodule

// ===== src/stepper_slew_limited_positioner_core.sv =====
// Slew-limited stepper position tracker. Every command on i_cmd (tick, set
// target, clear stall, energize, deenergize) yields exactly one result on
// o_res. A command passes an input register and a result register, and its
// result is then offered on o_res; one command per cycle is sustained while
// o_res keeps taking results. The cycle time is set by the tick path from
// the stored position and last-tick time through the elapsed-time by rate
// multiply, the step clamp and the limit compare back into the state
// registers. Configuration writes on i_cfg are always taken; index 0 is
// steps per ms, 1 the low limit, 2 the high limit, and index 3 is ignored.
module stepper_slew_limited_positioner_core #(
    parameter int unsigned POSITION_BITS = sslp_pkg::POSITION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sslp_cfg_if.sink    i_cfg,
    sslp_cmd_if.sink    i_cmd,
    sslp_res_if.source  o_res
);
    import sslp_pkg::*;

    t_cfg                            r_cfg;
    t_flags                          r_flags, n_flags;
    logic signed [POSITION_BITS-1:0] r_position, n_position;
    logic signed [POSITION_BITS-1:0] r_target, n_target;
    logic [31:0]                     r_last_tick, n_last_tick;
    logic                            r_in_valid, r_out_valid;
    t_cmd                            r_cmd;
    t_res                            r_res, n_res;
    logic                            s1_adv, s1_fire, in_fire;

    assign i_cfg.ready = 1'b1;

    assign s1_adv      = !r_out_valid || o_res.ready;
    assign s1_fire     = r_in_valid && s1_adv;
    assign i_cmd.ready = !r_in_valid || s1_adv;
    assign in_fire     = i_cmd.valid && i_cmd.ready;

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steps_per_ms <= STEPS_PER_MS_RST;
            r_cfg.low_limit    <= LOW_LIMIT_RST;
            r_cfg.high_limit   <= HIGH_LIMIT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_STEPS_PER_MS: r_cfg.steps_per_ms <= i_cfg.data[15:0];
                CFG_LOW_LIMIT:    r_cfg.low_limit    <= i_cfg.data;
                CFG_HIGH_LIMIT:   r_cfg.high_limit   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    sslp_step #(
        .POSITION_BITS(POSITION_BITS)
    ) u_step (
        .i_cmd      (r_cmd),
        .i_cfg      (r_cfg),
        .i_flags    (r_flags),
        .i_position (r_position),
        .i_target   (r_target),
        .i_last_tick(r_last_tick),
        .o_flags    (n_flags),
        .o_position (n_position),
        .o_target   (n_target),
        .o_last_tick(n_last_tick),
        .o_res      (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '{stalled: 1'b0, energized: 1'b1};
            r_position  <= '0;
            r_target    <= '0;
            r_last_tick <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (s1_fire) begin
                r_in_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
                r_position  <= n_position;
                r_target    <= n_target;
                r_last_tick <= n_last_tick;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_cmd.data;
        end
        if (s1_fire) begin
            r_res <= n_res;
        end
    end

`include "stepper_slew_limited_positioner_core_assert.svh"

    `SSLP_CHECK_NOW(a_in_reg_free_ready, !r_in_valid, i_cmd.ready)
    `SSLP_CHECK_NEXT(a_result_follows, s1_fire, r_out_valid)
    `SSLP_CHECK_NEXT(a_stall_reported, s1_fire, r_res.stall_flag == r_flags.stalled)
    `SSLP_CHECK_NEXT(a_hold_deenergized, s1_fire && !r_flags.energized, $stable(r_position))
    `SSLP_CHECK_NEXT(a_hold_stalled, s1_fire && r_flags.stalled, $stable(r_position))

endmodule
